@@ sv/svpwm_sector_duty_calc_defines.svh @@
// ----------------------------------------------------------------------------
// SVPWM sector/duty calculator assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SVPWM_SECTOR_DUTY_CALC_DEFINES_SVH
`define SVPWM_SECTOR_DUTY_CALC_DEFINES_SVH
`ifndef SYNTHESIS
`define SVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define SVP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define SVP_ASSERT(lbl, prop)
`define SVP_ASSERT_RST(lbl, prop)
`endif
`endif

@@ sv/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// SVPWM package
// Word types and fixed-point constants shared by the calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package svpwm_pkg;
  localparam int VoltWidth     = 16;
  localparam int DutyFracBits  = 15;
  localparam int SqBits        = 20;
  localparam int Sqrt3Q20      = 1816187;

  typedef struct packed {
    logic signed [VoltWidth-1:0] volt_alpha;
    logic signed [VoltWidth-1:0] volt_beta;
    logic        [15:0]          bus_voltage;
  } in_word_t;

  typedef struct packed {
    logic [15:0] duty_phase_a;
    logic [15:0] duty_phase_b;
    logic [15:0] duty_phase_c;
    logic [2:0]  sector_number;
    logic        out_of_range;
  } out_word_t;
endpackage

@@ sv/svpwm_sector_duty_calc.sv @@
// ----------------------------------------------------------------------------
// SVPWM sector and duty calculator
// Sector from projection signs, active times by division, phase duties.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | word
// input   | in  | start_i / busy_o    | in_word_t
// result  | out | result_valid_o      | out_word_t
// Accepts one word per cycle; busy_o is tied low. Results go through two
// divider chains of F+1 stages (F = DUTY_FRAC_BITS) and an output register.
// Reset clears only the valid bits. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "svpwm_sector_duty_calc_defines.svh"
module svpwm_sector_duty_calc #(
  parameter int DUTY_FRAC_BITS = svpwm_pkg::DutyFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  svpwm_pkg::in_word_t  in_word_i,
  output logic                 result_valid_o,
  output svpwm_pkg::out_word_t result_o
);
  localparam int F   = DUTY_FRAC_BITS;
  localparam int PW  = svpwm_pkg::VoltWidth + 24;   // projection magnitude width
  localparam int DW  = PW + 2;            // numerator/denominator width
  localparam int QW  = F + 1;             // quotient width (up to one)
  localparam int LIM = 62 - F;
  localparam int TW  = 3 + 1 + 1 + DW + DW + 2;

  assign busy_o = 1'b0;

  // stage 1: projections
  logic                 v1_q;
  logic signed [PW:0]   r1_q, r2_q, r3_q;
  logic [15:0]          vb1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end
  always_ff @(posedge clk_i) begin
    r1_q  <= (PW+1)'(2 * 64'(signed'(svpwm_pkg::Sqrt3Q20)) * 64'(in_word_i.volt_beta));
    r2_q  <= (PW+1)'(64'(3) * 64'(in_word_i.volt_alpha) * 64'(1 << svpwm_pkg::SqBits)
                     - 64'(signed'(svpwm_pkg::Sqrt3Q20)) * 64'(in_word_i.volt_beta));
    r3_q  <= (PW+1)'(-64'(3) * 64'(in_word_i.volt_alpha) * 64'(1 << svpwm_pkg::SqBits)
                     - 64'(signed'(svpwm_pkg::Sqrt3Q20)) * 64'(in_word_i.volt_beta));
    vb1_q <= in_word_i.bus_voltage;
  end

  // stage 2: sector, x, y, d
  logic [2:0]    code2;
  logic [2:0]    sec_d;
  logic [PW-1:0] x_d, y_d;
  logic          v2_q;
  logic [2:0]    sec2_q;
  logic [DW-1:0] x2_q, s2_q, d2_q;
  logic [15:0]   vb2_q;

  function automatic logic [PW-1:0] posv(input logic signed [PW:0] v);
    return (v > 0) ? v[PW-1:0] : '0;
  endfunction

  always_comb begin
    code2 = {r3_q > 0, r2_q > 0, r1_q > 0};
    sec_d = 3'd0;
    x_d   = '0;
    y_d   = '0;
    unique case (code2)
      3'd1: begin sec_d = 3'd2; x_d = posv(-r2_q); y_d = posv(-r3_q); end
      3'd2: begin sec_d = 3'd6; x_d = posv(-r3_q); y_d = posv(-r1_q); end
      3'd3: begin sec_d = 3'd1; x_d = posv(r2_q);  y_d = posv(r1_q);  end
      3'd4: begin sec_d = 3'd4; x_d = posv(-r1_q); y_d = posv(-r2_q); end
      3'd5: begin sec_d = 3'd3; x_d = posv(r1_q);  y_d = posv(r3_q);  end
      3'd6: begin sec_d = 3'd5; x_d = posv(r3_q);  y_d = posv(r2_q);  end
      default: ;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    sec2_q <= sec_d;
    x2_q   <= DW'(x_d);
    s2_q   <= DW'(x_d) + DW'(y_d);
    d2_q   <= DW'({vb1_q, 21'd0});
    vb2_q  <= vb1_q;
  end

  // stage 3: choose divisions, pre-shift large denominators, clamp n to d
  logic          ovm3;
  logic [DW-1:0] n1, n2, dd1, dd2;
  logic          v3_q;
  logic [2:0]    sec3_q;
  logic          ovm3_q, zb3_q;
  logic [DW-1:0] n1_q, n2_q, dd1_q, dd2_q;

  function automatic logic [2*DW-1:0] norm(input logic [DW-1:0] n, input logic [DW-1:0] d);
    logic [DW-1:0] nn, dn;
    nn = n;
    dn = d;
    for (int i = 0; i < DW - LIM + 1; i++) begin
      if (LIM < DW && (dn >> LIM) != '0) begin
        nn = nn >> 1;
        dn = dn >> 1;
      end
    end
    if (nn > dn) nn = dn;
    return {nn, dn};
  endfunction

  always_comb begin
    ovm3 = s2_q > d2_q;
    {n1, dd1} = norm(x2_q, ovm3 ? s2_q : d2_q);
    {n2, dd2} = norm(ovm3 ? '0 : s2_q, d2_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    sec3_q <= sec2_q;
    ovm3_q <= ovm3;
    zb3_q  <= vb2_q == 16'd0;
    n1_q   <= n1;
    dd1_q  <= dd1;
    n2_q   <= n2;
    dd2_q  <= dd2;
  end

  // rounded quotient: floor((n*2^F + d/2)/d), split as hi/lo dividend.
  // hi = (n*2^F + d/2) >> QW; n <= d so hi < d*2^(F-QW+1) fits.
  logic [DW+QW-1:0] nd1, nd2;
  always_comb begin
    nd1 = ({{QW{1'b0}}, n1_q} << F) + (DW+QW)'(dd1_q >> 1);
    nd2 = ({{QW{1'b0}}, n2_q} << F) + (DW+QW)'(dd2_q >> 1);
  end

  logic [QW-1:0] q1, q2;
  logic [TW-1:0] t1_o, t2_o;
  logic [QW-1:0] q1_keep;
  logic [TW-1:0] t2_in;

  svpwm_div #(.QW(QW), .DW(DW), .TW(TW)) u_div1 (
    .clk_i   (clk_i),
    .num_hi_i(nd1[DW+QW-1:QW]),
    .num_lo_i(nd1[QW-1:0]),
    .den_i   (dd1_q),
    .tag_i   ({sec3_q, ovm3_q, zb3_q, nd2[DW+QW-1:QW], dd2_q, 2'b00}),
    .quo_o   (q1),
    .tag_o   (t1_o)
  );

  // second chain carries the first quotient in the tag, in place of the second high dividend
  logic [QW-1:0][QW-1:0] nd2_lo_q;
  logic [2*QW-1:0]       vd_q;
  always_ff @(posedge clk_i) begin
    nd2_lo_q <= {nd2_lo_q[QW-2:0], nd2[QW-1:0]};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else begin
      vd_q <= {vd_q[2*QW-2:0], v3_q};
    end
  end

  logic [2:0] sec_a;
  logic       ovm_a, zb_a;
  logic [DW-1:0] n2hi_a, dd2_a;
  assign {sec_a, ovm_a, zb_a, n2hi_a, dd2_a} = t1_o[TW-1:2];
  assign t2_in = {sec_a, ovm_a, zb_a, {(DW-QW){1'b0}}, q1, dd2_a, 2'b00};

  svpwm_div #(.QW(QW), .DW(DW), .TW(TW)) u_div2 (
    .clk_i   (clk_i),
    .num_hi_i(n2hi_a),
    .num_lo_i(nd2_lo_q[QW-1]),
    .den_i   (dd2_a),
    .tag_i   (t2_in),
    .quo_o   (q2),
    .tag_o   (t2_o)
  );

  // final stage: duties and phase mapping
  logic [2:0]    sec_f;
  logic          ovm_f, zb_f;
  logic [DW-1:0] q1w_f, unused_d;
  logic [QW+2:0] one_w, tx, ty, ta, tb, tc;
  logic [QW+2:0] da, db, dc;
  always_comb begin
    {sec_f, ovm_f, zb_f, q1w_f, unused_d} = t2_o[TW-1:2];
    one_w = (QW+3)'(1) << F;
    q1_keep = q1w_f[QW-1:0];
    tx = '0;
    ty = '0;
    if (sec_f != 3'd0 && !zb_f) begin
      tx = (QW+3)'(q1_keep);
      ty = ovm_f ? one_w - tx : (QW+3)'(q2) - tx;
    end
    ta = (one_w + tx + ty + (QW+3)'(2)) >> 2;
    tb = (one_w + ty - tx + (QW+3)'(2)) >> 2;
    tc = (one_w + (QW+3)'(2) - tx - ty) >> 2;
    unique case (sec_f)
      3'd1: begin da = ta; db = tb; dc = tc; end
      3'd2: begin da = tb; db = ta; dc = tc; end
      3'd3: begin da = tc; db = ta; dc = tb; end
      3'd4: begin da = tc; db = tb; dc = ta; end
      3'd5: begin da = tb; db = tc; dc = ta; end
      3'd6: begin da = ta; db = tc; dc = tb; end
      default: begin da = ta; db = ta; dc = ta; end
    endcase
    if (zb_f) begin
      da = '0;
      db = '0;
      dc = '0;
    end
  end

  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vd_q[2*QW-1];
    end
  end
  always_ff @(posedge clk_i) begin
    result_o.duty_phase_a  <= 16'(da);
    result_o.duty_phase_b  <= 16'(db);
    result_o.duty_phase_c  <= 16'(dc);
    result_o.sector_number <= sec_f;
    result_o.out_of_range  <= zb_f;
  end
  assign result_valid_o = vo_q;

  `SVP_ASSERT(a_busy_low, busy_o == 1'b0)
  `SVP_ASSERT(a_valid_flow, vd_q[2*QW-1] |=> result_valid_o)
  `SVP_ASSERT(a_no_sector7, result_valid_o |-> result_o.sector_number != 3'd7)
  `SVP_ASSERT_RST(a_rst_quiet, !rst_ni |-> !result_valid_o)
endmodule

@@ sv/svpwm_div.sv @@
// ----------------------------------------------------------------------------
// SVPWM ratio divider
// Pipelined restoring divider, one quotient bit per stage:
// q = floor(n / d), n has DW+QW bits, d has DW bits, n < d * 2^QW.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module svpwm_div #(
  parameter int QW = 16,
  parameter int DW = 40,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [TW-1:0] tag_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   sh;
    logic          ge;
    if (s == 0) begin : g_in
      assign rem_in = num_hi_i;
      assign low_in = num_lo_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_in
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end
    always_comb begin
      sh = {rem_in, low_in[QW-1]};
      ge = sh >= {1'b0, den_in};
    end
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
      low_q[s] <= {low_in[QW-2:0], ge};
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign quo_o = low_q[QW-1];
  assign tag_o = tag_q[QW-1];
endmodule
